FILE: src/rbb_pkg.sv
// Package for the 3x3 RGB box blur: frame size, field widths, pixel types
// and the reciprocal constants of the divide-by-9/6/4 step.
// No dependencies.
`default_nettype none

package rbb_pkg;

  localparam int FRAME_SIZE = 256;
  localparam int POS_W      = $clog2(FRAME_SIZE);
  localparam int CH_W       = 8;
  localparam int SUM_W      = 12;
  localparam int RECIP_W    = 15;
  localparam int RECIP_SHIFT = 16;

  localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;
  localparam logic [RECIP_W-1:0] RECIP_6 = 15'd10923;
  localparam logic [RECIP_W-1:0] RECIP_4 = 15'd16384;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t two_above;
    pixel_t above;
  } line_entry_t;

endpackage

`default_nettype wire

FILE: src/rbb_if.sv
// Valid/ready channel interfaces for the box blur: input pixels and
// blurred results. Depends on rbb_pkg.
`default_nettype none

interface rbb_pix_if import rbb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rbb_res_if import rbb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [7:0]      out_row;
  logic [7:0]      out_col;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            last_of_run;

  modport source (output valid, out_row, out_col, out_red, out_green, out_blue,
                  last_of_run, input ready);
  modport sink   (input valid, out_row, out_col, out_red, out_green, out_blue,
                  last_of_run, output ready);
endinterface

`default_nettype wire

FILE: src/rgb_box_blur_3x3_unit.sv
// 3x3 RGB box blur over a square frame; one line memory holds the two rows above.
// Depends on rbb_pkg and the channel interfaces in rbb_if.sv.
// Path: a pixel's first result passes stage B, the job register, stage C and stage D.
// Throughput: one pixel per cycle while the output is not stalled; the single result
//   datapath behind the line-memory read emits one result per cycle, so a pixel with
//   k results (up to 4) holds input back until its last result is taken; a pixel on the last row has two results.
// Reset: clears pipeline valid bits and the row/column counters; the line memory is
//   not cleared and needs no clearing pass.
`default_nettype none

module rgb_box_blur_3x3_unit import rbb_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  rbb_pix_if.sink   pix_in,
  rbb_res_if.source res_out
);

  typedef enum logic [1:0] {DIV_9, DIV_6, DIV_4} div_t;

  localparam logic [POS_W-1:0] LAST = POS_W'(FRAME_SIZE - 1);
  localparam int PROD_W = SUM_W + RECIP_W;

  // line memory
  line_entry_t line_mem [FRAME_SIZE];
  line_entry_t rd_data;
  logic             rd_en, wr_en;
  logic [POS_W-1:0] rd_addr, wr_addr;
  line_entry_t      wr_data;

  // position counters
  logic [POS_W-1:0] row_cnt, col_cnt;

  // stage B: memory read returns
  logic             b_valid;
  pixel_t           b_px;
  logic [POS_W-1:0] b_row, b_col;
  logic [3:0]       b_mask;
  logic             b_moves;
  pixel_t           win [9];
  pixel_t           win_next [9];

  // job register: window snapshot and pending results
  logic             j_valid;
  pixel_t           j_win [9];
  logic [POS_W-1:0] j_row, j_col;
  logic [3:0]       j_mask;
  logic [3:0]       j_sel, j_rest;
  logic             j_ready, j_fire;
  logic             j_rlo, j_clo, j_up, j_left;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;

  // stage C: sums
  logic             c_valid, c_ready;
  logic [SUM_W-1:0] c_sum_r, c_sum_g, c_sum_b;
  div_t             c_div;
  logic [POS_W-1:0] c_row, c_col;
  logic             c_last;
  logic [RECIP_W-1:0] c_recip;
  logic [PROD_W-1:0]  prod_r, prod_g, prod_b;

  // stage D: output register
  logic d_valid, d_ready;

  logic in_ready, in_fire;

  // ---------------- input and memory ----------------
  assign in_ready     = !b_valid || b_moves;
  assign pix_in.ready = in_ready;
  assign in_fire      = pix_in.valid && in_ready;

  assign rd_en   = in_fire;
  assign rd_addr = col_cnt;
  assign wr_en   = b_moves;
  assign wr_addr = b_col;
  assign wr_data = '{two_above: rd_data.above, above: b_px};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= line_mem[rd_addr];
    end
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (in_fire) begin
      if (col_cnt == LAST) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == LAST) ? '0 : row_cnt + POS_W'(1);
      end else begin
        col_cnt <= col_cnt + POS_W'(1);
      end
    end
  end

  // ---------------- stage B ----------------
  always_comb begin
    b_mask[0] = (b_row != '0) && (b_col != '0);
    b_mask[1] = (b_row != '0) && (b_col == LAST);
    b_mask[2] = (b_row == LAST) && (b_col != '0);
    b_mask[3] = (b_row == LAST) && (b_col == LAST);
  end

  assign b_moves = b_valid && ((b_mask == '0) || j_ready);

  always_comb begin
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = rd_data.two_above;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = rd_data.above;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = b_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_ready) begin
      b_valid <= in_fire;
    end
    if (in_fire) begin
      b_px  <= '{red: pix_in.red, green: pix_in.green, blue: pix_in.blue};
      b_row <= row_cnt;
      b_col <= col_cnt;
    end
    if (b_moves) begin
      win <= win_next;
    end
  end

  // ---------------- job register ----------------
  assign j_sel   = j_mask & (~j_mask + 4'd1);
  assign j_rest  = j_mask & ~j_sel;
  assign j_fire  = j_valid && c_ready;
  assign j_ready = !j_valid || (c_ready && (j_rest == '0));

  assign j_up   = j_sel[0] || j_sel[1];
  assign j_left = j_sel[0] || j_sel[2];
  assign j_rlo  = j_up   ? (j_row < POS_W'(2)) : 1'b1;
  assign j_clo  = j_left ? (j_col < POS_W'(2)) : 1'b1;

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        if ((a > 0 || !j_rlo) && (b > 0 || !j_clo)) begin
          sum_r = sum_r + SUM_W'(j_win[a*3+b].red);
          sum_g = sum_g + SUM_W'(j_win[a*3+b].green);
          sum_b = sum_b + SUM_W'(j_win[a*3+b].blue);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
    end else if (b_moves && (b_mask != '0)) begin
      j_valid <= 1'b1;
    end else if (j_fire && (j_rest == '0)) begin
      j_valid <= 1'b0;
    end
    if (b_moves && (b_mask != '0)) begin
      j_win  <= win_next;
      j_row  <= b_row;
      j_col  <= b_col;
      j_mask <= b_mask;
    end else if (j_fire) begin
      j_mask <= j_rest;
    end
  end

  // ---------------- stage C ----------------
  assign c_ready = !c_valid || d_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= j_fire;
    end
    if (j_fire) begin
      c_sum_r <= sum_r;
      c_sum_g <= sum_g;
      c_sum_b <= sum_b;
      c_row   <= j_up   ? j_row - POS_W'(1) : j_row;
      c_col   <= j_left ? j_col - POS_W'(1) : j_col;
      c_last  <= (j_rest == '0);
      if (j_rlo && j_clo) begin
        c_div <= DIV_4;
      end else if (j_rlo || j_clo) begin
        c_div <= DIV_6;
      end else begin
        c_div <= DIV_9;
      end
    end
  end

  always_comb begin
    case (c_div)
      DIV_9:   c_recip = RECIP_9;
      DIV_6:   c_recip = RECIP_6;
      DIV_4:   c_recip = RECIP_4;
      default: c_recip = RECIP_9;
    endcase
  end

  // floor(sum / n) as (sum * ceil(2^16 / n)) >> 16, exact for sums below 4096
  assign prod_r = PROD_W'(c_sum_r) * PROD_W'(c_recip);
  assign prod_g = PROD_W'(c_sum_g) * PROD_W'(c_recip);
  assign prod_b = PROD_W'(c_sum_b) * PROD_W'(c_recip);

  // ---------------- stage D ----------------
  assign d_ready       = !d_valid || res_out.ready;
  assign res_out.valid = d_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= c_valid;
    end
    if (d_ready && c_valid) begin
      res_out.out_row     <= 8'(c_row);
      res_out.out_col     <= 8'(c_col);
      res_out.out_red     <= prod_r[RECIP_SHIFT +: CH_W];
      res_out.out_green   <= prod_g[RECIP_SHIFT +: CH_W];
      res_out.out_blue    <= prod_b[RECIP_SHIFT +: CH_W];
      res_out.last_of_run <= c_last;
    end
  end

`ifndef ASSERT_OFF
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("line memory read and write hit the same column");

  a_job_has_work: assert property (@(posedge clk) disable iff (rst)
    j_valid |-> (j_mask != '0))
    else $error("job register valid with no pending results");

  a_b_holds: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_moves) |=> (b_valid && $stable(b_col) && $stable(rd_data.above)))
    else $error("stalled read stage lost its data");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    j_valid |-> $onehot(j_sel))
    else $error("result select not one-hot");
`endif

endmodule

`default_nettype wire
